// ===== rtl/core/sc2a_pkg.sv =====
package sc2a_pkg;

    // Character queue geometry.
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = 8;
    localparam int FILL_MAX   = (1 << FILL_W) - 1;
    localparam int CHAR_W     = 7;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        OP_SCANCODE = 1'b0,
        OP_READ     = 1'b1
    } op_t;

    // Set-1 codes with a special meaning.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_BREAK_MASK   = 8'h80;

    localparam int MAP_LEN = 58;

    localparam logic [CHAR_W-1:0] LOWER_MAP [0:MAP_LEN-1] = '{
        0, 0, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8,
        9, 113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 10,
        0, 97, 115, 100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0,
        92, 122, 120, 99, 118, 98, 110, 109, 44, 46, 47, 0, 42, 0, 32
    };

    localparam logic [CHAR_W-1:0] UPPER_MAP [0:MAP_LEN-1] = '{
        0, 0, 33, 64, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8,
        9, 81, 87, 69, 82, 84, 89, 85, 73, 79, 80, 123, 125, 10,
        0, 65, 83, 68, 70, 71, 72, 74, 75, 76, 58, 34, 126, 0,
        124, 90, 88, 67, 86, 66, 78, 77, 60, 62, 63, 0, 42, 0, 32
    };

    // Key event handed from the translator to the queue logic.
    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] ch;
    } key_ev_t;

    function automatic logic [CHAR_W-1:0] keymap_lookup(input logic       shift,
                                                        input logic [7:0] code);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (code < 8'(MAP_LEN)) begin
            ch = shift ? UPPER_MAP[code[5:0]] : LOWER_MAP[code[5:0]];
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/sc2a_keymap.sv =====
module sc2a_keymap
    import sc2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       key_fire,
    input  logic [7:0] scancode,
    output key_ev_t    key_ev
);

    logic shift_reg;
    logic shift_next;

    // Both shift keys share one flag; any other break code leaves it alone.
    always_comb begin
        shift_next = shift_reg;
        if (key_fire) begin
            if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE) begin
                shift_next = 1'b1;
            end else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK) begin
                shift_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else begin
            shift_reg <= shift_next;
        end
    end

    // Shift make codes map to zero in both tables, so they never push.
    always_comb begin
        key_ev.ch   = keymap_lookup(shift_reg, scancode);
        key_ev.push = ((scancode & SC_BREAK_MASK) == 8'h00) && (key_ev.ch != '0);
    end

endmodule

// ===== rtl/core/scancode_to_ascii_fifo_core.sv =====
// Channel  Dir  tdata                                    tuser
// s_       in   [7:0] scancode                           [0] operation (0 key, 1 read)
// m_       out  [6:0] ascii_code, [14:7] fill_level      [0] char_valid, [1] overflow
//
// One transaction in, one transaction out; a new input is taken every cycle
// while s_tready is high. Each result is registered and sits in an output
// register while m_tready is low; s_tready stays high as long as that
// register is free or is being emptied in the same cycle.
// Reset clears the pointers, the count and the shift flag; the character
// store itself needs no clearing because only written entries are read.
module scancode_to_ascii_fifo_core
    import sc2a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] ascii_code, [14:7] fill_level, [15] zero
    output logic [1:0]  m_tuser    // [0] char_valid, [1] overflow
);

    logic [CHAR_W-1:0] char_store_reg [0:FIFO_DEPTH-1];

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  count_reg, count_next;

    logic              out_valid_reg;
    logic              char_valid_reg;
    logic              overflow_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [CHAR_W-1:0] rd_data_reg;

    logic    s_fire;
    logic    is_read;
    logic    rd_hit;
    logic    fifo_full;
    logic    wr_en;
    logic    ovf;
    key_ev_t key_ev;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_read  = (op_t'(s_tuser[0]) == OP_READ);

    sc2a_keymap u_keymap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_fire (s_fire && !is_read),
        .scancode (s_tdata),
        .key_ev   (key_ev)
    );

    // One slot is always kept empty, so the count tops out at depth minus one.
    assign fifo_full = (count_reg == PTR_W'(FIFO_DEPTH - 1));
    assign rd_hit    = is_read && (count_reg != '0);
    assign wr_en     = !is_read && key_ev.push && !fifo_full;
    assign ovf       = !is_read && key_ev.push && fifo_full;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (s_fire && rd_hit) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end else if (s_fire && wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (s_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields; the read data register only loads on a read that hits,
    // so it holds its value through an output stall.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            char_valid_reg <= rd_hit;
            overflow_reg   <= ovf;
            if (count_next > PTR_W'(FILL_MAX)) begin
                fill_reg <= FILL_W'(FILL_MAX);
            end else begin
                fill_reg <= FILL_W'(count_next);
            end
        end
    end

    // Character store: one write or one registered read per cycle. A read
    // only touches an entry written at an earlier edge, so no bypass is needed.
    always_ff @(posedge aclk) begin
        if (s_fire && wr_en) begin
            char_store_reg[wr_ptr_reg] <= key_ev.ch;
        end
        if (s_fire && rd_hit) begin
            rd_data_reg <= char_store_reg[rd_ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, fill_reg, (char_valid_reg ? rd_data_reg : CHAR_W'(0))};
    assign m_tuser  = {overflow_reg, char_valid_reg};

endmodule
